### rtl/ask_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ackermann steering kinematics package
// Shared types, constants and helpers for the front, queue and back modules.
// ----------------------------------------------------------------------------
package ask_pkg;

  // Width of every configuration register.
  localparam int unsigned CFG_W = 31;

  // Quarter turn in Q2.16 radians, the largest steering angle magnitude.
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

  // Configuration register bundle.
  typedef struct packed {
    logic [CFG_W-1:0] axle_dist;
    logic [CFG_W-1:0] rear_track;
    logic [CFG_W-1:0] kingpin_spacing;
    logic [CFG_W-1:0] roll_radius;
    logic [CFG_W-1:0] curvature_limit;
  } cfg_t;

  // Item passed from the front to the back: speed and clamped curvature.
  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [31:0] curv;
  } cmd_t;

  // How a steering angle is produced.
  typedef enum logic [1:0] {
    AM_CORDIC,
    AM_ZERO,
    AM_HALFPI
  } ang_mode_e;

  // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    logic [31:0] m;
    m = a[31] ? 32'(-a) : 32'(a);
    return m;
  endfunction

endpackage

### rtl/ask_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ackermann front end: curvature divider
// Accepts commands, forms yaw over speed with a pipelined restoring divider
// (one quotient bit per stage) and clamps the result to the curvature limit.
// ----------------------------------------------------------------------------
module ask_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        linear_speed_i,
  input  logic signed [31:0]        yaw_rate_i,
  input  logic                      command_valid_i,
  input  logic [ask_pkg::CFG_W-1:0] curvature_limit_i,
  output logic                      push_o,
  output ask_pkg::cmd_t             cmd_o,
  input  logic                      full_i
);

  localparam int unsigned DivSteps = 48;

  typedef struct packed {
    logic [30:0]        rem;
    logic [47:0]        num;
    logic [47:0]        quo;
    logic [31:0]        dm;
    logic               neg;
    logic               vzero;
    logic signed [31:0] speed;
  } div_stage_t;

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t  n;
    logic [31:0] r2;
    logic [31:0] diff;
    n    = s;
    r2   = {s.rem, s.num[47]};
    diff = r2 - s.dm;
    if (r2 >= s.dm) begin
      n.rem = diff[30:0];
      n.quo = {s.quo[46:0], 1'b1};
    end else begin
      n.rem = r2[30:0];
      n.quo = {s.quo[46:0], 1'b0};
    end
    n.num = {s.num[46:0], 1'b0};
    return n;
  endfunction

  div_stage_t         st_q [DivSteps+1];
  logic [DivSteps:0]  vld_q;
  logic               adv;
  logic               accept;
  div_stage_t         entry;
  logic signed [31:0] v0;
  logic signed [31:0] w0;
  logic [30:0]        kmag;
  logic signed [31:0] kval;

  // The pipeline moves unless a finished item cannot enter the queue.
  assign adv        = !(vld_q[DivSteps] && full_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign push_o     = vld_q[DivSteps] && adv;

  // An invalid command is taken as zero speed and zero yaw.
  always_comb begin
    v0          = command_valid_i ? linear_speed_i : 32'sd0;
    w0          = command_valid_i ? yaw_rate_i : 32'sd0;
    entry.rem   = '0;
    entry.num   = {ask_pkg::mag32(w0), 16'b0};
    entry.quo   = '0;
    entry.dm    = ask_pkg::mag32(v0);
    entry.neg   = v0[31] ^ w0[31];
    entry.vzero = (v0 == 32'sd0);
    entry.speed = v0;
  end

  // Valid bits of the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DivSteps-1:0], accept};
    end
  end

  // Divider stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= entry;
      for (int j = 1; j <= DivSteps; j++) begin
        st_q[j] <= div_step(st_q[j-1]);
      end
    end
  end

  // Clamp the quotient magnitude, apply the sign and zero it for zero speed.
  always_comb begin
    if (st_q[DivSteps].quo > {17'b0, curvature_limit_i}) begin
      kmag = curvature_limit_i;
    end else begin
      kmag = st_q[DivSteps].quo[30:0];
    end
    if (st_q[DivSteps].vzero) begin
      kval = 32'sd0;
    end else if (st_q[DivSteps].neg) begin
      kval = -$signed({1'b0, kmag});
    end else begin
      kval = $signed({1'b0, kmag});
    end
    cmd_o.speed = st_q[DivSteps].speed;
    cmd_o.curv  = kval;
  end

endmodule

### rtl/ask_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ackermann command queue
// Short first-in first-out queue that decouples the front end from the back.
// ----------------------------------------------------------------------------
module ask_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ask_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ask_pkg::cmd_t pop_data_o,
  output logic          avail_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ask_pkg::cmd_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign avail_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/ask_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ackermann back end: wheel rates and steering angles
// Pipelined multipliers, a restoring divider per rear wheel and a vectoring
// CORDIC per front wheel, all advancing together into one output register.
// ----------------------------------------------------------------------------
module ask_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ask_pkg::cfg_t      cfg_i,
  input  logic               cmd_avail_i,
  input  ask_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] left_steer_angle_o,
  output logic signed [17:0] right_steer_angle_o,
  output logic signed [31:0] left_wheel_rate_o,
  output logic signed [31:0] right_wheel_rate_o,
  output logic               overflow_fault_o
);

  localparam int unsigned PreStages  = 5;
  localparam int unsigned MidStages  = 32;
  localparam int unsigned Stages     = PreStages + MidStages;
  localparam int unsigned CordicLast = 30;
  localparam logic signed [63:0] Two33 = 64'sh0000_0002_0000_0000;

  typedef struct packed {
    logic [30:0] rem;
    logic [30:0] low;
    logic [30:0] quo;
    logic        neg;
    logic        fault;
  } rate_stage_t;

  typedef struct packed {
    logic signed [42:0]  x;
    logic signed [42:0]  y;
    logic signed [32:0]  z;
    ask_pkg::ang_mode_e  mode;
    logic                neg;
  } cor_stage_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    logic [63:0] m;
    m = a[63] ? 64'(-a) : 64'(a);
    return m;
  endfunction

  // Elementary angles atan(2^-i) in Q2.30.
  function automatic logic signed [32:0] atan_step(input int i);
    logic signed [32:0] a;
    unique case (i)
      0:       a = 33'sd843314857;
      1:       a = 33'sd497837830;
      2:       a = 33'sd263043837;
      3:       a = 33'sd133525159;
      4:       a = 33'sd67021687;
      5:       a = 33'sd33543516;
      6:       a = 33'sd16775851;
      7:       a = 33'sd8388437;
      8:       a = 33'sd4194283;
      9:       a = 33'sd2097149;
      10:      a = 33'sd1048576;
      11:      a = 33'sd524288;
      default: a = 33'sd1 <<< (30 - i);
    endcase
    return a;
  endfunction

  // One restoring division step of the wheel rate quotient.
  function automatic rate_stage_t rate_step(input rate_stage_t s, input logic [30:0] r);
    rate_stage_t n;
    logic [31:0] r2;
    logic [31:0] diff;
    n    = s;
    r2   = {s.rem, s.low[30]};
    diff = r2 - {1'b0, r};
    if (r2 >= {1'b0, r}) begin
      n.rem = diff[30:0];
      n.quo = {s.quo[29:0], 1'b1};
    end else begin
      n.rem = r2[30:0];
      n.quo = {s.quo[29:0], 1'b0};
    end
    n.low = {s.low[29:0], 1'b0};
    return n;
  endfunction

  // One CORDIC vectoring rotation driving y towards zero.
  function automatic cor_stage_t cor_step(input cor_stage_t s, input int i);
    cor_stage_t         n;
    logic signed [42:0] xs;
    logic signed [42:0] ys;
    logic signed [32:0] zs;
    logic signed [42:0] dx;
    logic signed [42:0] dy;
    n  = s;
    xs = s.x;
    ys = s.y;
    zs = s.z;
    dx = ys >>> i;
    dy = xs >>> i;
    if (ys > 43'sd0) begin
      n.x = xs + dx;
      n.y = ys - dy;
      n.z = zs + atan_step(i);
    end else begin
      n.x = xs - dx;
      n.y = ys + dy;
      n.z = zs - atan_step(i);
    end
    return n;
  endfunction

  // Round the CORDIC angle to Q2.16, clamp it and apply the special cases.
  function automatic logic signed [17:0] finish_angle(input cor_stage_t s);
    logic signed [32:0] zs;
    logic signed [33:0] zr;
    logic signed [19:0] r;
    logic signed [19:0] a;
    zs = s.z;
    zr = zs + 34'sd8192;
    r  = 20'(zr >>> 14);
    unique case (s.mode)
      ask_pkg::AM_ZERO:   a = 20'sd0;
      ask_pkg::AM_HALFPI: a = ask_pkg::HALF_PI_Q16;
      default: begin
        if (r < 20'sd0) begin
          a = 20'sd0;
        end else if (r > ask_pkg::HALF_PI_Q16) begin
          a = ask_pkg::HALF_PI_Q16;
        end else begin
          a = r;
        end
      end
    endcase
    if (s.neg) begin
      a = -a;
    end
    return a[17:0];
  endfunction

  logic [Stages-1:0] vld_q;
  logic              out_valid_q;
  logic              adv;

  // Stage 0: item taken from the queue.
  logic signed [31:0] spd0_q, crv0_q;
  // Stage 1: products with the curvature.
  logic signed [31:0] spd1_q;
  logic signed [63:0] tk1_q, num1_q, kk1_q;
  logic signed [63:0] tk_p, wb_p, kk_p;
  // Stage 2: per-lane magnitudes and signs.
  logic [46:0]        fm2_q [2];
  logic               rneg2_q [2];
  logic [31:0]        vm2_q;
  logic [63:0]        ux2_q [2];
  logic [63:0]        uy2_q;
  ask_pkg::ang_mode_e mode2_q [2];
  logic               aneg2_q [2];
  // Stage 3: partial products and byte-wise leading one search.
  logic [55:0]        plo3_q [2];
  logic [54:0]        phi3_q [2];
  logic               rneg3_q [2];
  logic [7:0]         nz3_q [2];
  logic [2:0]         lead3_q [2][8];
  logic [63:0]        ux3_q [2];
  logic [63:0]        uy3_q;
  ask_pkg::ang_mode_e mode3_q [2];
  logic               aneg3_q [2];
  // Stage 4: full product and normalising shift position.
  logic [77:0]        p4_q [2];
  logic               rneg4_q [2];
  logic [5:0]         pos4_q [2];
  logic [63:0]        ux4_q [2];
  logic [63:0]        uy4_q;
  ask_pkg::ang_mode_e mode4_q [2];
  logic               aneg4_q [2];
  // Divider and CORDIC stages, then the rounded angles.
  rate_stage_t        rate_q [2][MidStages];
  cor_stage_t         cor_q [2][CordicLast+1];
  logic signed [17:0] ang_q [2];

  // Output registers.
  logic signed [17:0] lang_q, rang_q;
  logic signed [31:0] lrate_q, rrate_q;
  logic               fault_q;

  assign adv       = !(out_valid_q && out_stall_i);
  assign cmd_pop_o = adv && cmd_avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Stages-2:0], cmd_pop_o};
      out_valid_q <= vld_q[Stages-1];
    end
  end

  // Curvature products.
  always_comb begin
    tk_p = $signed({1'b0, cfg_i.rear_track}) * crv0_q;
    wb_p = $signed({1'b0, cfg_i.axle_dist}) * crv0_q;
    kk_p = $signed({1'b0, cfg_i.kingpin_spacing}) * crv0_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] g;
    logic signed [63:0] den;
    logic [63:0]        gm;
    logic [63:0]        w;
    logic [2:0]         lead;
    logic [5:0]         pos;
    logic [63:0]        xw;
    logic [63:0]        yw;
    logic [77:0]        prod;
    rate_stage_t        rs;
    cor_stage_t         cs;
    logic signed [31:0] rl;
    logic signed [31:0] rr;
    logic               flt;
    if (adv) begin
      // Stage 0.
      spd0_q <= cmd_i.speed;
      crv0_q <= cmd_i.curv;

      // Stage 1.
      spd1_q <= spd0_q;
      tk1_q  <= tk_p;
      num1_q <= wb_p <<< 1;
      kk1_q  <= kk_p;

      // Stage 2: lane 0 is the left side (minus), lane 1 the right (plus).
      vm2_q <= ask_pkg::mag32(spd1_q);
      uy2_q <= mag64(num1_q);
      for (int l = 0; l < 2; l++) begin
        g           = (l == 0) ? Two33 - tk1_q : Two33 + tk1_q;
        gm          = mag64(g);
        fm2_q[l]   <= gm[63:17];
        rneg2_q[l] <= spd1_q[31] ^ g[63];
        den         = (l == 0) ? Two33 - kk1_q : Two33 + kk1_q;
        ux2_q[l]   <= mag64(den);
        if (num1_q == 64'sd0) begin
          mode2_q[l] <= ask_pkg::AM_ZERO;
          aneg2_q[l] <= 1'b0;
        end else if (den == 64'sd0) begin
          mode2_q[l] <= ask_pkg::AM_HALFPI;
          aneg2_q[l] <= num1_q[63];
        end else begin
          mode2_q[l] <= ask_pkg::AM_CORDIC;
          aneg2_q[l] <= num1_q[63] ^ den[63];
        end
      end

      // Stage 3.
      uy3_q <= uy2_q;
      for (int l = 0; l < 2; l++) begin
        plo3_q[l]  <= vm2_q * fm2_q[l][23:0];
        phi3_q[l]  <= vm2_q * fm2_q[l][46:24];
        rneg3_q[l] <= rneg2_q[l];
        w = ux2_q[l] | uy2_q;
        for (int b = 0; b < 8; b++) begin
          nz3_q[l][b] <= (w[8*b +: 8] != 8'd0);
          lead = 3'd0;
          for (int t = 0; t < 8; t++) begin
            if (w[8*b + t]) begin
              lead = 3'(t);
            end
          end
          lead3_q[l][b] <= lead;
        end
        ux3_q[l]   <= ux2_q[l];
        mode3_q[l] <= mode2_q[l];
        aneg3_q[l] <= aneg2_q[l];
      end

      // Stage 4.
      uy4_q <= uy3_q;
      for (int l = 0; l < 2; l++) begin
        p4_q[l]    <= 78'(plo3_q[l]) + 78'({phi3_q[l], 24'b0});
        rneg4_q[l] <= rneg3_q[l];
        pos = 6'd0;
        for (int b = 0; b < 8; b++) begin
          if (nz3_q[l][b]) begin
            pos = {3'(b), lead3_q[l][b]};
          end
        end
        pos4_q[l]  <= pos;
        ux4_q[l]   <= ux3_q[l];
        mode4_q[l] <= mode3_q[l];
        aneg4_q[l] <= aneg3_q[l];
      end

      // First mid stage: overflow test, divider start and normalised vector.
      for (int l = 0; l < 2; l++) begin
        prod     = p4_q[l];
        rs.rem   = prod[61:31];
        rs.low   = prod[30:0];
        rs.quo   = '0;
        rs.neg   = rneg4_q[l];
        rs.fault = (cfg_i.roll_radius == '0) || (prod[77:31] >= 47'(cfg_i.roll_radius));
        rate_q[l][0] <= rs;

        if (pos4_q[l] > 6'd39) begin
          xw = ux4_q[l] >> (pos4_q[l] - 6'd39);
          yw = uy4_q >> (pos4_q[l] - 6'd39);
        end else begin
          xw = ux4_q[l] << (6'd39 - pos4_q[l]);
          yw = uy4_q << (6'd39 - pos4_q[l]);
        end
        cs.x    = $signed({3'b0, xw[39:0]});
        cs.y    = $signed({3'b0, yw[39:0]});
        cs.z    = '0;
        cs.neg  = aneg4_q[l];
        cs.mode = mode4_q[l];
        if (mode4_q[l] == ask_pkg::AM_CORDIC && yw[39:0] == 40'd0) begin
          cs.mode = ask_pkg::AM_ZERO;
        end
        cor_q[l][0] <= cs;
      end

      // Divider and CORDIC iterations.
      for (int l = 0; l < 2; l++) begin
        for (int j = 1; j < MidStages; j++) begin
          rate_q[l][j] <= rate_step(rate_q[l][j-1], cfg_i.roll_radius);
        end
        for (int j = 1; j <= CordicLast; j++) begin
          cor_q[l][j] <= cor_step(cor_q[l][j-1], j - 1);
        end
        ang_q[l] <= finish_angle(cor_q[l][CordicLast]);
      end

      // Output stage: an overflow on either wheel zeroes every result.
      flt = rate_q[0][MidStages-1].fault | rate_q[1][MidStages-1].fault;
      rl  = rate_q[0][MidStages-1].neg ? -$signed({1'b0, rate_q[0][MidStages-1].quo})
                                        : $signed({1'b0, rate_q[0][MidStages-1].quo});
      rr  = rate_q[1][MidStages-1].neg ? -$signed({1'b0, rate_q[1][MidStages-1].quo})
                                        : $signed({1'b0, rate_q[1][MidStages-1].quo});
      fault_q <= flt;
      lrate_q <= flt ? 32'sd0 : rl;
      rrate_q <= flt ? 32'sd0 : rr;
      lang_q  <= flt ? 18'sd0 : ang_q[0];
      rang_q  <= flt ? 18'sd0 : ang_q[1];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign left_steer_angle_o  = lang_q;
  assign right_steer_angle_o = rang_q;
  assign left_wheel_rate_o   = lrate_q;
  assign right_wheel_rate_o  = rrate_q;
  assign overflow_fault_o    = fault_q;

endmodule

### rtl/ackermann_steering_kinematics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ackermann steering inverse kinematics
// Turns a speed and yaw rate command into rear wheel rates and front steering
// angles, with overflow detection on the wheel rates.
// ----------------------------------------------------------------------------
// The block takes one command item per clock cycle while in_stall_o is low and
// returns one result item for each, in order. An item passes through the
// curvature divider of the front end, the command queue and the back end, whose
// length is set by the 31-step wheel rate divider running beside the 30-step
// CORDIC. The queue lets the front end keep accepting items while a result waits
// to be taken. The configuration registers may only be written while no item is
// in flight.
// ----------------------------------------------------------------------------
module ackermann_steering_kinematics_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_index_i,
  input  logic [ask_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        linear_speed_i,
  input  logic signed [31:0]        yaw_rate_i,
  input  logic                      command_valid_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [17:0]        left_steer_angle_o,
  output logic signed [17:0]        right_steer_angle_o,
  output logic signed [31:0]        left_wheel_rate_o,
  output logic signed [31:0]        right_wheel_rate_o,
  output logic                      overflow_fault_o
);

  localparam logic [2:0] CFG_AXLE_DIST   = 3'd0;
  localparam logic [2:0] CFG_REAR_TRACK  = 3'd1;
  localparam logic [2:0] CFG_KINGPIN     = 3'd2;
  localparam logic [2:0] CFG_ROLL_RADIUS = 3'd3;
  localparam logic [2:0] CFG_CURV_LIMIT  = 3'd4;
  localparam logic [ask_pkg::CFG_W-1:0] CfgReset = 31'd65536;

  ask_pkg::cfg_t cfg_q;
  ask_pkg::cmd_t front_cmd;
  ask_pkg::cmd_t queue_cmd;
  logic          push;
  logic          full;
  logic          pop;
  logic          avail;

  // Configuration registers; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axle_dist       <= CfgReset;
      cfg_q.rear_track      <= CfgReset;
      cfg_q.kingpin_spacing <= CfgReset;
      cfg_q.roll_radius     <= CfgReset;
      cfg_q.curvature_limit <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_AXLE_DIST:   cfg_q.axle_dist       <= cfg_data_i;
        CFG_REAR_TRACK:  cfg_q.rear_track      <= cfg_data_i;
        CFG_KINGPIN:     cfg_q.kingpin_spacing <= cfg_data_i;
        CFG_ROLL_RADIUS: cfg_q.roll_radius     <= cfg_data_i;
        CFG_CURV_LIMIT:  cfg_q.curvature_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: curvature.
  ask_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .linear_speed_i    (linear_speed_i),
    .yaw_rate_i        (yaw_rate_i),
    .command_valid_i   (command_valid_i),
    .curvature_limit_i (cfg_q.curvature_limit),
    .push_o            (push),
    .cmd_o             (front_cmd),
    .full_i            (full)
  );

  // Queue between the two halves.
  ask_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (queue_cmd),
    .avail_o     (avail)
  );

  // Back end: wheel rates and steering angles.
  ask_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_avail_i         (avail),
    .cmd_i               (queue_cmd),
    .cmd_pop_o           (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .left_steer_angle_o  (left_steer_angle_o),
    .right_steer_angle_o (right_steer_angle_o),
    .left_wheel_rate_o   (left_wheel_rate_o),
    .right_wheel_rate_o  (right_wheel_rate_o),
    .overflow_fault_o    (overflow_fault_o)
  );

endmodule

### rtl/ask_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ackermann steering kinematics checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ask_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [17:0] left_steer_angle_o,
  input logic signed [17:0] right_steer_angle_o,
  input logic signed [31:0] left_wheel_rate_o,
  input logic signed [31:0] right_wheel_rate_o,
  input logic               overflow_fault_o
);

  // No result can appear in the cycle after reset has been held.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result item shown straight after reset");

  // A stalled result item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result item withdrawn");

  // A stalled result item keeps its wheel rates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(left_wheel_rate_o) && $stable(right_wheel_rate_o))
    else $error("stalled result item changed");

  // An overflow zeroes both wheel rates and both steering angles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_fault_o |->
      left_wheel_rate_o == 32'sd0 && right_wheel_rate_o == 32'sd0 &&
      left_steer_angle_o == 18'sd0 && right_steer_angle_o == 18'sd0)
    else $error("overflow result item not zeroed");

  // Steering angles never pass a quarter turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      left_steer_angle_o <= ask_pkg::HALF_PI_Q16 &&
      left_steer_angle_o >= -ask_pkg::HALF_PI_Q16 &&
      right_steer_angle_o <= ask_pkg::HALF_PI_Q16 &&
      right_steer_angle_o >= -ask_pkg::HALF_PI_Q16)
    else $error("steering angle out of range");

endmodule

bind ackermann_steering_kinematics_top ask_checker u_ask_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .left_steer_angle_o  (left_steer_angle_o),
  .right_steer_angle_o (right_steer_angle_o),
  .left_wheel_rate_o   (left_wheel_rate_o),
  .right_wheel_rate_o  (right_wheel_rate_o),
  .overflow_fault_o    (overflow_fault_o)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ackermann steering kinematics testbench
// Sends speed and yaw rate commands under several register settings, predicts
// the wheel rates, steering angles and overflow flag of each item, and checks
// every result in order against the prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_AXLE_DIST,
    REG_REAR_TRACK,
    REG_KINGPIN,
    REG_ROLL_RADIUS,
    REG_CURV_LIMIT
  } reg_idx_e;

  typedef struct {
    logic signed [17:0] left_angle;
    logic signed [17:0] right_angle;
    logic signed [31:0] lw_rate;
    logic signed [31:0] rw_rate;
    logic               fault;
  } kin_result_t;

  localparam int          IDLE_LIMIT = 5000;
  localparam int          PHASE_ITEMS = 300;
  localparam longint      HALF_PI = 102944;
  localparam logic [30:0] REG_MAX = 31'h7fff_ffff;

  localparam longint ATAN_TAB [12] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [2:0]                cfg_index_i = '0;
  logic [ask_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [31:0]        linear_speed_i = '0;
  logic signed [31:0]        yaw_rate_i = '0;
  logic                      command_valid_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [17:0]        left_steer_angle_o;
  logic signed [17:0]        right_steer_angle_o;
  logic signed [31:0]        left_wheel_rate_o;
  logic signed [31:0]        right_wheel_rate_o;
  logic                      overflow_fault_o;

  ackermann_steering_kinematics_top dut (.*);

  // Local copy of the registers and the results still owed by the block.
  longint unsigned geom_regs [5];
  kin_result_t     pending_results [$];
  int              err_cnt = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;
  int              stall_mode = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned mag64(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  // Vectoring-mode arctangent of uy / ux in Q2.16, operands non-negative.
  function automatic longint atan_q16(longint unsigned ux, longint unsigned uy);
    longint x, y, z, dx, dy, r, sa;
    z = 0;
    while ((ux | uy) >= (64'd1 << 40)) begin
      ux = ux >> 1;
      uy = uy >> 1;
    end
    while ((ux | uy) != 0 && (ux | uy) < (64'd1 << 39)) begin
      ux = ux << 1;
      uy = uy << 1;
    end
    if (uy == 0) return 0;
    x = ux;
    y = uy;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      sa = (i < 12) ? ATAN_TAB[i] : (longint'(1) << (30 - i));
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + sa;
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - sa;
      end
    end
    r = (z + 8192) >>> 14;
    if (r < 0) r = 0;
    if (r > HALF_PI) r = HALF_PI;
    return r;
  endfunction

  function automatic longint steer_q16(longint num, longint den);
    longint a;
    bit neg;
    if (num == 0) return 0;
    if (den == 0) begin
      a = HALF_PI;
      neg = num < 0;
    end else begin
      a = atan_q16(mag64(den), mag64(num));
      neg = (num < 0) != (den < 0);
    end
    return neg ? -a : a;
  endfunction

  // One rear wheel rate; returns 1 when the rate would overflow.
  function automatic bit wheel_rate(longint v, longint g, longint unsigned r,
                                    output longint rate);
    longint unsigned fm, vm, q;
    fm = mag64(g) >> 17;
    vm = mag64(v);
    rate = 0;
    if (r == 0) return 1'b1;
    if (fm == 0 || vm == 0) return 1'b0;
    if (vm > ((r << 31) - 1) / fm) return 1'b1;
    q = vm * fm / r;
    rate = ((v < 0) != (g < 0)) ? -longint'(q) : longint'(q);
    return 1'b0;
  endfunction

  function automatic kin_result_t predict_kinematics(logic signed [31:0] speed,
                                                     logic signed [31:0] yaw,
                                                     logic cmd_ok);
    kin_result_t res;
    longint v, w, k, lim, tk, lr, rr, la, ra, num, kk;
    bit fault;
    v = 0;
    w = 0;
    k = 0;
    la = 0;
    ra = 0;
    lim = geom_regs[REG_CURV_LIMIT];
    if (cmd_ok) begin
      v = speed;
      w = yaw;
    end
    if (v != 0) begin
      k = (w * 65536) / v;
      if (k > lim) k = lim;
      if (k < -lim) k = -lim;
    end
    tk = longint'(geom_regs[REG_REAR_TRACK]) * k;
    fault = wheel_rate(v, (longint'(1) << 33) - tk, geom_regs[REG_ROLL_RADIUS], lr);
    if (wheel_rate(v, (longint'(1) << 33) + tk, geom_regs[REG_ROLL_RADIUS], rr))
      fault = 1'b1;
    if (fault) begin
      lr = 0;
      rr = 0;
    end else begin
      num = 2 * longint'(geom_regs[REG_AXLE_DIST]) * k;
      kk = longint'(geom_regs[REG_KINGPIN]) * k;
      la = steer_q16(num, (longint'(1) << 33) - kk);
      ra = steer_q16(num, (longint'(1) << 33) + kk);
    end
    res.left_angle = la[17:0];
    res.right_angle = ra[17:0];
    res.lw_rate = lr[31:0];
    res.rw_rate = rr[31:0];
    res.fault = fault;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    err_cnt++;
  endtask

  // Result checking and the watchdog on accepted items.
  always @(posedge clk_i) begin
    kin_result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result items outstanding", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (left_steer_angle_o !== want.left_angle)
            report_mismatch("left_steer_angle", left_steer_angle_o, want.left_angle);
          if (right_steer_angle_o !== want.right_angle)
            report_mismatch("right_steer_angle", right_steer_angle_o, want.right_angle);
          if (left_wheel_rate_o !== want.lw_rate)
            report_mismatch("left_wheel_rate", left_wheel_rate_o, want.lw_rate);
          if (right_wheel_rate_o !== want.rw_rate)
            report_mismatch("right_wheel_rate", right_wheel_rate_o, want.rw_rate);
          if (overflow_fault_o !== want.fault)
            report_mismatch("overflow_fault", overflow_fault_o, want.fault);
        end
      end
    end
  end

  // The receiver stalls on one of four patterns, picked anew at random.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  // Sends one command item in bursts with random gaps in between.
  task automatic send_cmd(logic signed [31:0] speed, logic signed [31:0] yaw,
                          logic cmd_ok);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    linear_speed_i <= speed;
    yaw_rate_i <= yaw;
    command_valid_i <= cmd_ok;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_kinematics(speed, yaw, cmd_ok));
    @(negedge clk_i);
  endtask

  // Waits for every owed result, then lets the pipeline go quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    geom_regs[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(logic [30:0] wb, logic [30:0] rt, logic [30:0] kp,
                                logic [30:0] wr, logic [30:0] cl);
    write_reg(REG_AXLE_DIST, wb);
    write_reg(REG_REAR_TRACK, rt);
    write_reg(REG_KINGPIN, kp);
    write_reg(REG_ROLL_RADIUS, wr);
    write_reg(REG_CURV_LIMIT, cl);
  endtask

  function automatic logic [30:0] rand_geom();
    return 31'($urandom >> $urandom_range(1, 31));
  endfunction

  // Extremes of the fields, invalid commands and zero speed.
  task automatic test_directed();
    send_cmd(32'sd0, 32'sd0, 1'b1);
    send_cmd(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_cmd(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_cmd(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
    send_cmd(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_cmd(32'sd65536, 32'sd65536, 1'b1);
    send_cmd(32'sd65536, -32'sd65536, 1'b1);
    send_cmd(32'sd0, 32'sd65536, 1'b1);
    send_cmd(32'sd1, 32'sh8000_0000, 1'b1);
    send_cmd(-32'sd1, 32'sh7fff_ffff, 1'b1);
    send_cmd(32'sd65536, 32'sd0, 1'b1);
    send_cmd(32'sd262144, 32'sd65536, 1'b1);
    send_cmd(32'sh8000_0000, 32'sd1, 1'b1);
    send_cmd(32'sd123456, -32'sd987654, 1'b0);
    send_cmd(-32'sd65536, 32'sd32768, 1'b1);
    send_cmd(-32'sd1, -32'sd1, 1'b1);
  endtask

  // Mostly moderate speeds with varied turn rates, plus some noise.
  task automatic test_random(int n_items, bit with_pause);
    logic signed [31:0] speed, yaw;
    logic cmd_ok;
    for (int i = 0; i < n_items; i++) begin
      if (with_pause && i == n_items / 2) drain_results();
      cmd_ok = ($urandom_range(0, 9) != 0);
      yaw = $signed($urandom) >>> $urandom_range(0, 31);
      case ($urandom_range(0, 9))
        0: begin
          speed = $urandom;
          yaw = $urandom;
        end
        7: speed = 32'sd0;
        8: speed = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        9: begin
          speed = $signed($urandom) >>> $urandom_range(0, 31);
          yaw = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        default: begin
          speed = $urandom_range(1, 32'h0010_0000);
          if ($urandom_range(0, 1)) speed = -speed;
        end
      endcase
      send_cmd(speed, yaw, cmd_ok);
    end
  endtask

  task automatic test_phase(bit with_pause);
    test_directed();
    test_random(PHASE_ITEMS, with_pause);
    drain_results();
  endtask

  initial begin
    geom_regs = '{65536, 65536, 65536, 65536, 65536};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values.
    test_phase(1'b1);
    // Largest geometry everywhere.
    write_all_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    test_phase(1'b0);
    // Smallest non-zero geometry.
    write_all_regs(31'd1, 31'd1, 31'd1, 31'd1, 31'd1);
    test_phase(1'b0);
    // Zero axle distance and zero limit, then zero rolling radius.
    write_all_regs(31'd0, 31'd65536, 31'd0, 31'd65536, 31'd0);
    test_phase(1'b0);
    write_all_regs(31'd131072, 31'd0, 31'd98304, 31'd0, 31'd65536);
    test_phase(1'b0);
    // Random geometry.
    write_all_regs(rand_geom(), rand_geom(), rand_geom(), rand_geom(), rand_geom());
    test_phase(1'b1);

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### ackermann_steering_kinematics_top.f
rtl/ask_pkg.sv
rtl/ask_front.sv
rtl/ask_queue.sv
rtl/ask_back.sv
rtl/ackermann_steering_kinematics_top.sv
rtl/ask_checker.sv
sim/tb_top.sv
